// ----- rtl/core/rpa_pkg.sv -----
package rpa_pkg;

  localparam int ADDR_W   = 56;
  localparam int CFG_W    = 56;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;
  localparam int FREE_W   = 16;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADDREF = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAULT = 2'd3;

  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_PAGES = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  localparam logic [ADDR_W-1:0] RESET_BASE  = 56'h0000_0080_000_000;
  localparam int                RESET_PAGES = 32768;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_ADDREF,
    KIND_BAD
  } rpa_kind_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_ISSUE,
    S_EXEC
  } rpa_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_addr;
    logic [COUNT_W-1:0]  new_count;
    logic                returned_to_pool;
    logic [FREE_W-1:0]   free_pages;
  } rpa_result_t;

endpackage

// ----- rtl/core/rpa_ram.sv -----
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/rpa_queue.sv -----
module rpa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/rpa_front.sv -----
module rpa_front #(
  parameter int PAGE_SHIFT = 12,
  parameter int PG_W       = 15,
  parameter int CNT_W      = 16
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpa_pkg::OP_W-1:0]      in_operation,
  input  logic [rpa_pkg::ADDR_W-1:0]    in_page_addr,
  input  logic [rpa_pkg::ADDR_W-PAGE_SHIFT-1:0] base_pg,
  input  logic [CNT_W-1:0]              pool_pages,
  input  logic                          busy,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [PG_W+1:0]               q_data
);

  import rpa_pkg::*;

  localparam int APG_W = ADDR_W - PAGE_SHIFT;

  logic [APG_W-1:0] addr_pg;
  logic [APG_W-1:0] diff;
  logic             in_pool;
  rpa_kind_t        kind;

  assign addr_pg = in_page_addr[ADDR_W-1:PAGE_SHIFT];
  assign diff    = addr_pg - base_pg;
  assign in_pool = (addr_pg >= base_pg) && (diff < APG_W'(pool_pages));

  always_comb begin
    unique case (in_operation)
      OP_ALLOC:  kind = KIND_ALLOC;
      OP_FREE:   kind = in_pool ? KIND_FREE : KIND_BAD;
      OP_ADDREF: kind = in_pool ? KIND_ADDREF : KIND_BAD;
      default:   kind = KIND_BAD;
    endcase
  end

  assign in_stall = q_full || busy;
  assign q_push   = in_valid && !in_stall;
  assign q_data   = {kind, diff[PG_W-1:0]};

endmodule

// ----- rtl/core/rpa_back.sv -----
module rpa_back #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int PG_W       = 15,
  parameter int CNT_W      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  refill,
  input  logic [CNT_W-1:0]                      refill_pages,
  input  logic [CNT_W-1:0]                      reset_pages,
  input  logic [CNT_W-1:0]                      pool_pages,
  input  logic [rpa_pkg::ADDR_W-PAGE_SHIFT-1:0] base_pg,
  output logic                                  busy,
  input  logic                                  q_valid,
  input  logic [PG_W+1:0]                       q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rpa_pkg::rpa_result_t                  out_res
);

  import rpa_pkg::*;

  localparam int APG_W = ADDR_W - PAGE_SHIFT;
  localparam logic [PG_W-1:0] CLR_LAST = PG_W'(NUM_PAGES - 1);

  rpa_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  free_top_r, free_top_nxt;
  logic [PG_W-1:0]   clr_idx_r, clr_idx_nxt;
  rpa_kind_t         kind_r, kind_nxt;
  logic [PG_W-1:0]   idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  rpa_result_t       out_r, res;
  logic              load;

  rpa_kind_t         q_kind;
  logic [PG_W-1:0]   q_idx;
  logic [CNT_W-1:0]  ft_dec;
  logic              slot_free;
  logic [APG_W-1:0]  alloc_pg;

  logic              st_we, st_re;
  logic [PG_W-1:0]   st_waddr, st_wdata, st_raddr, st_rdata;
  logic              cn_we, cn_re;
  logic [PG_W-1:0]   cn_waddr, cn_raddr;
  logic [COUNT_W-1:0] cn_wdata, cn_rdata;

  assign q_kind    = rpa_kind_t'(q_data[PG_W+1:PG_W]);
  assign q_idx     = q_data[PG_W-1:0];
  assign ft_dec    = free_top_r - 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign alloc_pg  = base_pg + APG_W'(st_rdata);
  assign busy      = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  rpa_ram #(.WIDTH(PG_W), .DEPTH(NUM_PAGES), .AW(PG_W)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rpa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_PAGES), .AW(PG_W)) u_count (
    .clk   (clk),
    .we    (cn_we),
    .waddr (cn_waddr),
    .wdata (cn_wdata),
    .re    (cn_re),
    .raddr (cn_raddr),
    .rdata (cn_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == CLR_LAST) state_nxt = S_ISSUE;
      S_ISSUE: if (q_valid) state_nxt = S_EXEC;
      S_EXEC:  if (slot_free) state_nxt = S_ISSUE;
      default: state_nxt = S_CLEAR;
    endcase
    if (refill) begin
      state_nxt = S_CLEAR;
    end
  end

  always_comb begin
    q_pop        = 1'b0;
    st_we        = 1'b0;
    st_waddr     = clr_idx_r;
    st_wdata     = clr_idx_r;
    st_re        = 1'b0;
    st_raddr     = ft_dec[PG_W-1:0];
    cn_we        = 1'b0;
    cn_waddr     = clr_idx_r;
    cn_wdata     = '0;
    cn_re        = 1'b0;
    cn_raddr     = q_idx;
    clr_idx_nxt  = clr_idx_r;
    free_top_nxt = free_top_r;
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    load         = 1'b0;
    res          = '0;
    unique case (state_r)
      S_CLEAR: begin
        st_we       = 1'b1;
        cn_we       = 1'b1;
        clr_idx_nxt = PG_W'(clr_idx_r + 1'b1);
      end
      S_ISSUE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          kind_nxt = q_kind;
          idx_nxt  = q_idx;
          st_re    = (q_kind == KIND_ALLOC);
          cn_re    = (q_kind == KIND_FREE) || (q_kind == KIND_ADDREF);
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          load = 1'b1;
          unique case (kind_r)
            KIND_ALLOC: begin
              if (free_top_r == '0) begin
                res.status = ST_OOM;
              end else begin
                cn_we           = 1'b1;
                cn_waddr        = st_rdata;
                cn_wdata        = COUNT_ONE;
                free_top_nxt    = ft_dec;
                res.status      = ST_OK;
                res.new_count   = COUNT_ONE;
                res.result_addr = {alloc_pg, {PAGE_SHIFT{1'b0}}};
              end
            end
            KIND_FREE: begin
              cn_waddr = idx_r;
              if (cn_rdata == '0) begin
                res.status = ST_FAULT;
              end else if (cn_rdata != COUNT_ONE) begin
                cn_we         = 1'b1;
                cn_wdata      = cn_rdata - 1'b1;
                res.new_count = cn_rdata - 1'b1;
              end else begin
                cn_we    = 1'b1;
                cn_wdata = '0;
                if (free_top_r < pool_pages) begin
                  st_we                = 1'b1;
                  st_waddr             = free_top_r[PG_W-1:0];
                  st_wdata             = idx_r;
                  free_top_nxt         = CNT_W'(free_top_r + 1'b1);
                  res.returned_to_pool = 1'b1;
                end
              end
            end
            KIND_ADDREF: begin
              cn_waddr = idx_r;
              if (cn_rdata == COUNT_MAX) begin
                res.status    = ST_FAULT;
                res.new_count = COUNT_MAX;
              end else begin
                cn_we         = 1'b1;
                cn_wdata      = cn_rdata + 1'b1;
                res.new_count = cn_rdata + 1'b1;
              end
            end
            KIND_BAD: begin
              res.status = ST_BAD;
            end
            default: begin
              res.status = ST_BAD;
            end
          endcase
          res.free_pages = FREE_W'(free_top_nxt);
        end
      end
      default: begin
        clr_idx_nxt = '0;
      end
    endcase
    if (refill) begin
      clr_idx_nxt  = '0;
      free_top_nxt = refill_pages;
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      free_top_r  <= reset_pages;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_top_r  <= free_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    if (load) begin
      out_r <= res;
    end
  end

endmodule

// ----- rtl/core/refcounted_page_allocator.sv -----
// Page frame allocator with 8-bit reference counts and a LIFO free-page stack.
// Each request (allocate, free, add reference) yields one result transaction.
// In the back end a request first reads the count or stack memory and then
// updates the memories, and the back end finishes one request before it takes
// the next from the queue; a 2-entry queue behind the address classifier
// keeps requests flowing while a result waits on out_stall. After reset and
// after every pool_pages write, a clearing pass rewrites both memories
// (stack entry i = page i, counts zero); in_stall stays high for its duration
// while configuration writes are still taken.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rpa_pkg::OP_W-1:0]        in_operation,
  input  logic [rpa_pkg::ADDR_W-1:0]      in_page_addr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rpa_pkg::STATUS_W-1:0]    out_status,
  output logic [rpa_pkg::ADDR_W-1:0]      out_result_addr,
  output logic [rpa_pkg::COUNT_W-1:0]     out_new_count,
  output logic                            out_returned_to_pool,
  output logic [rpa_pkg::FREE_W-1:0]      out_free_pages
);

  import rpa_pkg::*;

  localparam int PG_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int CMP_W = (CNT_W > FREE_W) ? CNT_W : FREE_W;
  localparam int APG_W = ADDR_W - PAGE_SHIFT;
  localparam int Q_DEPTH = 2;
  localparam logic [CNT_W-1:0] RESET_CLIP =
    (RESET_PAGES > NUM_PAGES) ? CNT_W'(NUM_PAGES) : CNT_W'(RESET_PAGES);

  logic [APG_W-1:0] base_pg_r;
  logic [CNT_W-1:0] pool_pages_r;
  logic [CMP_W-1:0] cfg_pages_wide;
  logic [CNT_W-1:0] cfg_pages_clip;
  logic             refill;

  logic             q_push, q_full, q_pop, q_valid;
  logic [PG_W+1:0]  q_wdata, q_rdata;
  logic             busy;
  rpa_result_t      res;

  assign cfg_pages_wide = CMP_W'(cfg_wdata[FREE_W-1:0]);
  assign cfg_pages_clip = (cfg_pages_wide > CMP_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                               : CNT_W'(cfg_pages_wide);
  assign refill = cfg_we && (cfg_index == REG_POOL_PAGES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_pg_r    <= RESET_BASE[ADDR_W-1:PAGE_SHIFT];
      pool_pages_r <= RESET_CLIP;
    end else if (cfg_we) begin
      if (cfg_index == REG_POOL_BASE) begin
        base_pg_r <= cfg_wdata[ADDR_W-1:PAGE_SHIFT];
      end else begin
        pool_pages_r <= cfg_pages_clip;
      end
    end
  end

  rpa_front #(.PAGE_SHIFT(PAGE_SHIFT), .PG_W(PG_W), .CNT_W(CNT_W)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_page_addr (in_page_addr),
    .base_pg      (base_pg_r),
    .pool_pages   (pool_pages_r),
    .busy         (busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  rpa_queue #(.WIDTH(PG_W + 2), .DEPTH(Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_rdata)
  );

  rpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .PG_W       (PG_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .refill       (refill),
    .refill_pages (cfg_pages_clip),
    .reset_pages  (RESET_CLIP),
    .pool_pages   (pool_pages_r),
    .base_pg      (base_pg_r),
    .busy         (busy),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_status           = res.status;
  assign out_result_addr      = res.result_addr;
  assign out_new_count        = res.new_count;
  assign out_returned_to_pool = res.returned_to_pool;
  assign out_free_pages       = res.free_pages;

endmodule
